/* hdl/bgpi_pkg.sv */
// Shared types, sizes and helpers of the bilinear grid point interpolator.
// Used by every module under hdl but bgpi_ram; depends on nothing.
package bgpi_pkg;

   localparam int GRID_POINTS = 4096;
   localparam int MAX_CELLS   = 63;
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int FRAC_ONE    = 1 << FRAC_BITS;
   localparam int NUM_AXES    = 3;

   localparam int GRID_AW     = $clog2(GRID_POINTS);
   localparam int IDX_W       = GRID_AW + 1;
   localparam int CELL_W      = 6;
   localparam int ROW_W       = CELL_W + 1;
   localparam int PARAM_W     = 17;
   localparam int WEIGHT_W    = FRAC_BITS + 1;
   localparam int SU_W        = PARAM_W + CELL_W;
   localparam int IU_W        = SU_W - FRAC_BITS;
   localparam int POINT_W     = NUM_AXES * COORD_WIDTH;

   // blend arithmetic widths
   localparam int PROD_W      = COORD_WIDTH + WEIGHT_W + 1;
   localparam int HI_W        = PROD_W - FRAC_BITS;
   localparam int HPROD_W     = HI_W + WEIGHT_W + 1;
   localparam int LPROD_W     = FRAC_BITS + WEIGHT_W;
   localparam int LSUM_W      = LPROD_W + 1;

   localparam int CMD_DEPTH   = 4;
   localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH   = 8;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_U_CELLS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_V_CELLS = 2'd1;
   localparam logic [CELL_W-1:0]      CELLS_RESET = 6'd32;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                          req_type;
      logic [GRID_AW-1:0]            point_index;
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
      logic [PARAM_W-1:0]            param_u;
      logic [PARAM_W-1:0]            param_v;
   } bgpi_request_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] result_x;
      logic signed [COORD_WIDTH-1:0] result_y;
      logic signed [COORD_WIDTH-1:0] result_z;
      logic                          out_of_range;
   } bgpi_result_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } bgpi_point_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_QUERY,
      CMD_RANGE
   } bgpi_cmd_kind_type;

   // addr is the write index for CMD_WRITE and the base corner for CMD_QUERY
   typedef struct packed {
      bgpi_cmd_kind_type    kind;
      logic [IDX_W-1:0]     addr;
      logic [ROW_W-1:0]     row;
      logic [WEIGHT_W-1:0]  wu;
      logic [WEIGHT_W-1:0]  wv;
      bgpi_point_type       point;
   } bgpi_command_type;

   // a count of zero acts as one, anything above the limit as the limit
   function automatic logic [CELL_W-1:0] eff_cells(input logic [CELL_W-1:0] c);
      logic [CELL_W-1:0] r;
      r = c;
      if (c == '0) begin
         r = CELL_W'(1);
      end else if (int'(c) > MAX_CELLS) begin
         r = CELL_W'(MAX_CELLS);
      end
      return r;
   endfunction

endpackage

/* hdl/bgpi_ram.sv */
// Generic single-write, single-read memory with registered read data.
// Holds the grid points; no dependencies.
module bgpi_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/bgpi_front.sv */
// Front part: accepts requests, holds the cell-count registers and turns
// each request into a write, query or range command. Uses bgpi_pkg.
module bgpi_front
   import bgpi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  bgpi_request_type       req_data,
   input  logic                   valid,
   output logic                   ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CELL_W-1:0]      csr_wdata,
   output logic                   cmd_push,
   output bgpi_command_type       cmd_data,
   input  logic [CMD_CNT_W-1:0]   cmd_count
);

   logic [CELL_W-1:0]        u_cells_ff, u_cells_in;
   logic [CELL_W-1:0]        v_cells_ff, v_cells_in;
   logic                     f1_vld_ff, f1_vld_in;
   bgpi_request_type         f1_req_ff;
   logic [SU_W-1:0]          su_ff, su_in;
   logic [SU_W-1:0]          sv_ff, sv_in;
   logic                     f1_oor_ff, f1_oor_in;
   logic [CELL_W-1:0]        nu, nv;
   logic [CMD_CNT_W:0]       backlog;
   logic                     accept;
   logic [IU_W-1:0]          iu_raw, jv_raw;
   logic [CELL_W-1:0]        iu, jv;
   logic [WEIGHT_W-1:0]      wu, wv;
   logic [ROW_W-1:0]         row;
   logic [CELL_W+ROW_W-1:0]  row_off;
   logic [IDX_W-1:0]         base;

   assign nu = eff_cells(u_cells_ff);
   assign nv = eff_cells(v_cells_ff);

   // count the request in the first stage against queue room
   assign backlog = {1'b0, cmd_count} + (CMD_CNT_W+1)'(f1_vld_ff);
   assign full    = backlog >= (CMD_CNT_W+1)'(CMD_DEPTH);
   assign accept  = push & ~full;
   assign ready   = 1'b1;

   always_comb begin
      u_cells_in = u_cells_ff;
      v_cells_in = v_cells_ff;
      if (valid && csr_index == CSR_U_CELLS) begin
         u_cells_in = csr_wdata;
      end
      if (valid && csr_index == CSR_V_CELLS) begin
         v_cells_in = csr_wdata;
      end
   end

   assign f1_vld_in = accept;
   assign su_in     = SU_W'(req_data.param_u) * SU_W'(nu);
   assign sv_in     = SU_W'(req_data.param_v) * SU_W'(nv);
   assign f1_oor_in = (req_data.param_u > PARAM_W'(FRAC_ONE)) ||
                      (req_data.param_v > PARAM_W'(FRAC_ONE));

   always_ff @(posedge clock) begin
      if (reset) begin
         u_cells_ff <= CELLS_RESET;
         v_cells_ff <= CELLS_RESET;
         f1_vld_ff  <= 1'b0;
      end else begin
         u_cells_ff <= u_cells_in;
         v_cells_ff <= v_cells_in;
         f1_vld_ff  <= f1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_req_ff <= req_data;
         su_ff     <= su_in;
         sv_ff     <= sv_in;
         f1_oor_ff <= f1_oor_in;
      end
   end

   // cell and weight; a parameter of one lands in the last cell at full weight
   assign iu_raw = su_ff[SU_W-1:FRAC_BITS];
   assign jv_raw = sv_ff[SU_W-1:FRAC_BITS];

   always_comb begin
      if (iu_raw >= IU_W'(nu)) begin
         iu = nu - CELL_W'(1);
         wu = WEIGHT_W'(FRAC_ONE);
      end else begin
         iu = iu_raw[CELL_W-1:0];
         wu = WEIGHT_W'(su_ff[FRAC_BITS-1:0]);
      end
      if (jv_raw >= IU_W'(nv)) begin
         jv = nv - CELL_W'(1);
         wv = WEIGHT_W'(FRAC_ONE);
      end else begin
         jv = jv_raw[CELL_W-1:0];
         wv = WEIGHT_W'(sv_ff[FRAC_BITS-1:0]);
      end
   end

   assign row     = ROW_W'(nu) + ROW_W'(1);
   assign row_off = (CELL_W+ROW_W)'(jv) * (CELL_W+ROW_W)'(row);
   assign base    = IDX_W'(row_off) + IDX_W'(iu);

   always_comb begin
      cmd_data.row     = row;
      cmd_data.wu      = wu;
      cmd_data.wv      = wv;
      cmd_data.point.x = f1_req_ff.point_x;
      cmd_data.point.y = f1_req_ff.point_y;
      cmd_data.point.z = f1_req_ff.point_z;
      priority if (f1_req_ff.req_type == REQ_WRITE) begin
         cmd_data.kind = CMD_WRITE;
         cmd_data.addr = IDX_W'(f1_req_ff.point_index);
      end else if (f1_oor_ff) begin
         cmd_data.kind = CMD_RANGE;
         cmd_data.addr = base;
      end else begin
         cmd_data.kind = CMD_QUERY;
         cmd_data.addr = base;
      end
   end

   assign cmd_push = f1_vld_ff;

endmodule

/* hdl/bgpi_cmd_fifo.sv */
// Short command queue between the front and back parts, show-ahead head.
// Uses bgpi_pkg for the command type and depth.
module bgpi_cmd_fifo
   import bgpi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bgpi_command_type     push_data,
   input  logic                 pop,
   output logic                 head_vld,
   output bgpi_command_type     head_data,
   output logic [CMD_CNT_W-1:0] count
);

   bgpi_command_type       slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   do_pop;

   assign head_vld  = count_ff != '0;
   assign head_data = slot_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign do_pop    = pop & head_vld;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + CMD_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CMD_CNT_W'(push) - CMD_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/bgpi_back.sv */
// Back part: runs commands against the grid memory, blends the four corners
// in a multiply pipeline and queues the results. Uses bgpi_pkg, bgpi_ram.
module bgpi_back
   import bgpi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_vld,
   input  bgpi_command_type  cmd_data,
   output logic              cmd_pop,
   output logic              empty,
   input  logic              pop,
   output bgpi_result_type   rsp_data
);

   typedef struct packed {
      logic                vld;
      logic [1:0]          corner;
      logic                oor;
      logic                zero;
      logic [WEIGHT_W-1:0] wu;
      logic [WEIGHT_W-1:0] wv;
   } bgpi_tag_type;

   typedef struct packed {
      logic                vld;
      logic                row;
      logic                oor;
      logic [WEIGHT_W-1:0] wv;
   } bgpi_rtag_type;

   typedef struct packed {
      logic vld;
      logic row;
      logic oor;
   } bgpi_stag_type;

   // issue
   logic [1:0]             cnt_ff, cnt_in;
   logic [RSP_CNT_W-1:0]   rsv_ff, rsv_in;
   logic                   produce, credit_ok, go, last, is_query, rsp_take;
   logic [IDX_W-1:0]       corner_addr;
   logic                   rd_en, wr_en;
   bgpi_tag_type           t1_ff, t1_in, t2_ff;
   bgpi_rtag_type          t3_ff, t3_in;
   bgpi_stag_type          t4_ff, t4_in, t5_ff;
   bgpi_point_type         rd_point;

   // datapath per axis
   logic [WEIGHT_W-1:0]        w_u, w_v;
   logic signed [COORD_WIDTH-1:0] coord   [NUM_AXES];
   logic signed [PROD_W-1:0]   prod_in  [NUM_AXES];
   logic signed [PROD_W-1:0]   prod_ff  [NUM_AXES];
   logic signed [PROD_W-1:0]   acc_ff   [NUM_AXES];
   logic signed [PROD_W-1:0]   a_ff     [NUM_AXES];
   logic signed [HI_W-1:0]     hi       [NUM_AXES];
   logic signed [HPROD_W-1:0]  hp_in    [NUM_AXES];
   logic signed [HPROD_W-1:0]  hp_ff    [NUM_AXES];
   logic [LPROD_W-1:0]         lp_in    [NUM_AXES];
   logic [LPROD_W-1:0]         lp_ff    [NUM_AXES];
   logic signed [HPROD_W-1:0]  hs_ff    [NUM_AXES];
   logic [LPROD_W-1:0]         ls_ff    [NUM_AXES];
   logic signed [HPROD_W-1:0]  sh_ff    [NUM_AXES];
   logic [LSUM_W-1:0]          sl_ff    [NUM_AXES];
   logic signed [HPROD_W-1:0]  tot      [NUM_AXES];

   // result queue
   bgpi_result_type        rq_ff [RSP_DEPTH];
   bgpi_result_type        rq_push_data;
   logic [RSP_PTR_W-1:0]   rq_wr_ff, rq_wr_in, rq_rd_ff, rq_rd_in;
   logic [RSP_CNT_W-1:0]   rq_cnt_ff, rq_cnt_in;

   // ---------------------------------------------------------------- issue
   assign is_query  = cmd_data.kind == CMD_QUERY;
   assign produce   = cmd_data.kind != CMD_WRITE;
   assign credit_ok = rsv_ff < RSP_CNT_W'(RSP_DEPTH);
   assign go        = cmd_vld && (!produce || cnt_ff != 2'd0 || credit_ok);
   assign last      = !is_query || cnt_ff == 2'd3;
   assign cmd_pop   = go && last;
   assign rsp_take  = pop && !empty;

   // corners in order: base, base+1, base+row, base+row+1
   assign corner_addr = cmd_data.addr + IDX_W'(cnt_ff[0]) +
                        (cnt_ff[1] ? IDX_W'(cmd_data.row) : IDX_W'(0));

   assign rd_en = go && is_query;
   assign wr_en = go && cmd_data.kind == CMD_WRITE &&
                  cmd_data.addr < IDX_W'(GRID_POINTS);

   always_comb begin
      cnt_in = cnt_ff;
      if (go) begin
         cnt_in = last ? 2'd0 : cnt_ff + 2'd1;
      end
      // reserve a result slot when a query or range command starts
      rsv_in = rsv_ff + RSP_CNT_W'(go && produce && cnt_ff == 2'd0) -
               RSP_CNT_W'(rsp_take);
      t1_in.vld    = go && produce;
      t1_in.corner = is_query ? cnt_ff : 2'd3;
      t1_in.oor    = !is_query;
      t1_in.zero   = corner_addr >= IDX_W'(GRID_POINTS);
      t1_in.wu     = cmd_data.wu;
      t1_in.wv     = cmd_data.wv;
   end

   bgpi_ram #(
      .WIDTH (POINT_W),
      .DEPTH (GRID_POINTS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd_data.addr[GRID_AW-1:0]),
      .wr_data (cmd_data.point),
      .rd_en   (rd_en),
      .rd_addr (corner_addr[GRID_AW-1:0]),
      .rd_data (rd_point)
   );

   // ------------------------------------------------------ blend along u
   assign w_u = t1_ff.corner[0] ? t1_ff.wu : WEIGHT_W'(FRAC_ONE) - t1_ff.wu;

   always_comb begin
      coord[0] = rd_point.x;
      coord[1] = rd_point.y;
      coord[2] = rd_point.z;
      for (int k = 0; k < NUM_AXES; k++) begin
         if (t1_ff.zero) begin
            coord[k] = '0;
         end
         prod_in[k] = coord[k] * $signed({1'b0, w_u});
      end
   end

   // ------------------------------------------------------ blend along v
   assign w_v = t3_ff.row ? t3_ff.wv : WEIGHT_W'(FRAC_ONE) - t3_ff.wv;

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         hi[k]    = a_ff[k][PROD_W-1:FRAC_BITS];
         hp_in[k] = hi[k] * $signed({1'b0, w_v});
         lp_in[k] = LPROD_W'(a_ff[k][FRAC_BITS-1:0]) * LPROD_W'(w_v);
         // floor of the exact sum over 2^16
         tot[k]   = sh_ff[k] + HPROD_W'(sl_ff[k][LSUM_W-1:FRAC_BITS]);
      end
   end

   always_comb begin
      t3_in.vld = t2_ff.vld && t2_ff.corner[0];
      t3_in.row = t2_ff.corner[1];
      t3_in.oor = t2_ff.oor;
      t3_in.wv  = t2_ff.wv;
      t4_in.vld = t3_ff.vld;
      t4_in.row = t3_ff.row;
      t4_in.oor = t3_ff.oor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rsv_ff <= '0;
         t1_ff  <= '0;
         t2_ff  <= '0;
         t3_ff  <= '0;
         t4_ff  <= '0;
         t5_ff  <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         rsv_ff    <= rsv_in;
         t1_ff     <= t1_in;
         t2_ff     <= t1_ff;
         t3_ff     <= t3_in;
         t4_ff     <= t4_in;
         t5_ff.vld <= t4_ff.vld && t4_ff.row;
         t5_ff.row <= t4_ff.row;
         t5_ff.oor <= t4_ff.oor;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_AXES; k++) begin
         prod_ff[k] <= prod_in[k];
         if (t2_ff.vld && !t2_ff.corner[0]) begin
            acc_ff[k] <= prod_ff[k];
         end
         if (t2_ff.vld && t2_ff.corner[0]) begin
            a_ff[k] <= acc_ff[k] + prod_ff[k];
         end
         hp_ff[k] <= hp_in[k];
         lp_ff[k] <= lp_in[k];
         if (t4_ff.vld && !t4_ff.row) begin
            hs_ff[k] <= hp_ff[k];
            ls_ff[k] <= lp_ff[k];
         end
         if (t4_ff.vld && t4_ff.row) begin
            sh_ff[k] <= hs_ff[k] + hp_ff[k];
            sl_ff[k] <= LSUM_W'(ls_ff[k]) + LSUM_W'(lp_ff[k]);
         end
      end
   end

   // --------------------------------------------------------- result queue
   always_comb begin
      if (t5_ff.oor) begin
         rq_push_data.result_x = '0;
         rq_push_data.result_y = '0;
         rq_push_data.result_z = '0;
      end else begin
         rq_push_data.result_x = tot[0][FRAC_BITS +: COORD_WIDTH];
         rq_push_data.result_y = tot[1][FRAC_BITS +: COORD_WIDTH];
         rq_push_data.result_z = tot[2][FRAC_BITS +: COORD_WIDTH];
      end
      rq_push_data.out_of_range = t5_ff.oor;
      rq_wr_in  = t5_ff.vld ? rq_wr_ff + RSP_PTR_W'(1) : rq_wr_ff;
      rq_rd_in  = rsp_take  ? rq_rd_ff + RSP_PTR_W'(1) : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff + RSP_CNT_W'(t5_ff.vld) - RSP_CNT_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (t5_ff.vld) begin
         rq_ff[rq_wr_ff] <= rq_push_data;
      end
   end

   assign empty    = rq_cnt_ff == '0;
   assign rsp_data = rq_ff[rq_rd_ff];

endmodule

/* hdl/bilinear_grid_point_interpolator.sv */
// Bilinear grid point interpolator, top level.
// Holds a grid of x/y/z points in one memory and answers (u, v) queries
// with the bilinear blend of the four surrounding points.
//
// Request side is a queue: an item is taken when push is high and full is
// low. A write item stores one grid point and gives no result; a query gives
// exactly one result. Results come out in order: the oldest one sits on
// rsp_data while empty is low and leaves when pop is high.
// Cell counts are written through valid/ready (ready is always high) with
// csr_index 0 for u cells and 1 for v cells. The user must write them only
// while the block is idle; the block itself does not enforce it.
//
// Port use: a write takes one access of the memory port, a query one read
// per corner from the single grid read port, so writes go at one per cycle
// while no query holds the port or waits ahead of them.
// Reset clears the queues and loads 32 into both cell counts; grid contents
// stay as they were. While pop is low results collect in an eight-deep
// queue; once it is reserved up, queries wait in the four-deep command
// queue and full rises when that fills.
module bilinear_grid_point_interpolator
   import bgpi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  bgpi_request_type       req_data,
   output logic                   empty,
   input  logic                   pop,
   output bgpi_result_type        rsp_data,
   input  logic                   valid,
   output logic                   ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CELL_W-1:0]      csr_wdata
);

   logic                  cmd_push;
   bgpi_command_type      cmd_in_data;
   logic [CMD_CNT_W-1:0]  cmd_count;
   logic                  cmd_vld;
   bgpi_command_type      cmd_head;
   logic                  cmd_pop;

   bgpi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .valid     (valid),
      .ready     (ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in_data),
      .cmd_count (cmd_count)
   );

   bgpi_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .pop       (cmd_pop),
      .head_vld  (cmd_vld),
      .head_data (cmd_head),
      .count     (cmd_count)
   );

   bgpi_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_vld  (cmd_vld),
      .cmd_data (cmd_head),
      .cmd_pop  (cmd_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   a_cmd_room: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> (cmd_count < CMD_CNT_W'(CMD_DEPTH)))
      else $error("command pushed into a full queue");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.out_of_range) |->
         (rsp_data.result_x == '0 && rsp_data.result_y == '0 &&
          rsp_data.result_z == '0))
      else $error("out-of-range result carries nonzero coordinates");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (empty && cmd_count == '0))
      else $error("queues not empty after reset");

endmodule
